// ===== src/ternary_search_engine_defines.svh =====
// Assertion macros shared by the ternary search engine checkers.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef TERNARY_SEARCH_ENGINE_DEFINES_SVH
`define TERNARY_SEARCH_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define TSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define TSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tse_pkg.sv =====
// Shared types and constants for the ternary search engine.
// No dependencies; imported by the controller, datapath and top level.
package tse_pkg;

	localparam int IDX_W      = 10;
	localparam int OPCODE_W   = 1;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int M_TDATA_W  = ((IDX_W + 7) / 8) * 8;

	localparam logic [OPCODE_W-1:0] OP_WRITE  = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_SEARCH = 1'b1;

	localparam logic REG_FIRST = 1'b0;
	localparam logic REG_LAST  = 1'b1;

	// Commands from controller to datapath.
	typedef struct packed {
		logic write;
		logic load;
		logic third;
		logic probe;
		logic decide;
		logic publish;
	} tse_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic empty;
		logic hit;
		logic out_free;
	} tse_status_t;

endpackage

// ===== src/tse_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module tse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== src/tse_ctrl.sv =====
// Sequencer of the ternary search engine: accepts beats, steps the rounds.
// Depends on tse_pkg.
module tse_ctrl
	import tse_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [OPCODE_W-1:0] opcode,
	output logic                in_ready,
	input  tse_status_t         status,
	output tse_cmd_t            cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_THIRD  = 5'b00010,
		ST_PROBE  = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_REPORT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == OP_SEARCH) begin
						cmd.load = 1'b1;
						state_d  = ST_THIRD;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_THIRD: begin
				if (status.empty) begin
					state_d = ST_REPORT;
				end else begin
					cmd.third = 1'b1;
					state_d   = ST_PROBE;
				end
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = status.hit ? ST_REPORT : ST_THIRD;
			end
			ST_REPORT: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/tse_datapath.sv =====
// Datapath of the ternary search engine: bounds, third-point arithmetic,
// value table, compare and output register. Depends on tse_pkg and tse_ram.
module tse_datapath
	import tse_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tse_cmd_t                      cmd,
	output tse_status_t                   status,
	input  logic [IDX_W-1:0]              entry_index,
	input  logic signed [VALUE_WIDTH-1:0] entry_value,
	input  logic signed [VALUE_WIDTH-1:0] search_key,
	input  logic [IDX_W-1:0]              first_index,
	input  logic [IDX_W-1:0]              last_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_found,
	output logic [IDX_W-1:0]              out_position
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW = (AW > IDX_W) ? AW : IDX_W;   // width of a bound difference
	localparam int CW = NW + 2;                      // signed bound width
	localparam int TW = NW - 1;                      // width of a third
	localparam logic [NW:0] RECIP = (NW + 1)'(((1 << (NW + 2)) + 2) / 3);
	localparam logic signed [CW-1:0] DEPTH_M1 = CW'(TABLE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_U = CW'(TABLE_DEPTH);

	logic signed [CW-1:0]          lo_q, hi_q, m1_q, m2_q;
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic [TW-1:0]                 third_q;
	logic                          hit_q;
	logic [IDX_W-1:0]              hit_pos_q;
	logic                          out_valid_q, out_found_q;
	logic [IDX_W-1:0]              out_pos_q;

	logic [CW-1:0]                 idx_ext, first_ext, last_ext;
	logic signed [CW-1:0]          last_sat, diff_c, m1_c, m2_c, third_ext;
	logic [2*NW:0]                 prod_c;
	logic signed [VALUE_WIDTH-1:0] v1, v2;
	logic                          hit1, hit2;

	assign idx_ext   = {{(CW - IDX_W){1'b0}}, entry_index};
	assign first_ext = {{(CW - IDX_W){1'b0}}, first_index};
	assign last_ext  = {{(CW - IDX_W){1'b0}}, last_index};
	assign last_sat  = (signed'(last_ext) > DEPTH_M1) ? DEPTH_M1 : signed'(last_ext);

	// (hi - lo) / 3 by reciprocal multiply; exact for NW-bit differences
	assign diff_c    = hi_q - lo_q;
	assign prod_c    = (2 * NW + 1)'(diff_c[NW-1:0]) * (2 * NW + 1)'(RECIP);
	assign third_ext = {{(CW - TW){1'b0}}, third_q};
	assign m1_c      = lo_q + third_ext;
	assign m2_c      = hi_q - third_ext;

	tse_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (cmd.write && (idx_ext < DEPTH_U)),
		.waddr   (idx_ext[AW-1:0]),
		.wdata   (entry_value),
		.raddr_a (m1_c[AW-1:0]),
		.rdata_a (v1),
		.raddr_b (m2_c[AW-1:0]),
		.rdata_b (v2)
	);

	assign hit1 = (v1 == key_q);
	assign hit2 = (v2 == key_q);

	assign status.empty    = (hi_q < lo_q);
	assign status.hit      = hit1 || hit2;
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q      <= signed'(first_ext);
			hi_q      <= last_sat;
			key_q     <= search_key;
			hit_pos_q <= '0;
		end
		if (cmd.third) begin
			third_q <= prod_c[2*NW:NW+2];
		end
		if (cmd.probe) begin
			m1_q <= m1_c;
			m2_q <= m2_c;
		end
		if (cmd.decide) begin
			priority if (hit1) begin
				hit_pos_q <= m1_q[IDX_W-1:0];
			end else if (hit2) begin
				hit_pos_q <= m2_q[IDX_W-1:0];
			end else if (key_q < v1) begin
				hi_q <= m1_q - CW'(1);
			end else if (key_q > v2) begin
				lo_q <= m2_q + CW'(1);
			end else begin
				lo_q <= m1_q + CW'(1);
				hi_q <= m2_q - CW'(1);
			end
		end
		if (cmd.publish) begin
			out_found_q <= hit_q;
			out_pos_q   <= hit_pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				hit_q <= 1'b0;
			end else if (cmd.decide && (hit1 || hit2)) begin
				hit_q <= 1'b1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_found    = out_found_q;
	assign out_position = out_pos_q;

endmodule

// ===== src/ternary_search_engine.sv =====
// Ternary search engine, top level.
// Input stream (s_*): one beat per operation. s_tuser is the opcode: a write
// beat stores entry_value at entry_index (indexes at or past TABLE_DEPTH are
// dropped); a search beat looks up search_key over [first_index, last_index],
// last_index being clipped to TABLE_DEPTH-1. The table must be ascending and
// a search must only touch entries written before it.
// Output stream (m_*): one beat per search, none per write. m_tuser is found,
// m_tdata carries the matching index, or 0 when the key is absent.
// Timing: writes are accepted back to back. A search that hits raises m_tvalid
// after the compare of its last round, a miss once the range is found empty;
// s_tready returns in the same cycle as the result enters the output register.
// Each round is a third-point multiply, a dual-port read of both probes and a
// compare; at most seven rounds over 1024 entries.
// The sequencer starts the next beat in the cycle after handing its result to
// the output register; a stalled m_tready holds the result there and holds
// the sequencer in its report step until the register frees.
// Reset: controller and output valid clear; first_index = 0,
// last_index = 1023. The table has no reset and keeps no valid bits.
// Config (APB): register 0 first_index at 0x0, register 1 last_index at 0x4.
module ternary_search_engine
	import tse_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32,
	localparam int S_TDATA_W = ((IDX_W + 2 * VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // entry_index, entry_value, search_key, zero pad
	input  logic [OPCODE_W-1:0]   s_tuser,   // opcode
	// master stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // position, zero pad
	output logic                  m_tuser,   // found
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	tse_cmd_t    cmd;
	tse_status_t status;

	logic [IDX_W-1:0]              first_q, last_q;
	logic [IDX_W-1:0]              entry_index, out_position;
	logic signed [VALUE_WIDTH-1:0] entry_value, search_key;
	logic                          cfg_wr;

	// unpack the input beat, lowest field first
	assign entry_index = s_tdata[IDX_W-1:0];
	assign entry_value = s_tdata[IDX_W +: VALUE_WIDTH];
	assign search_key  = s_tdata[IDX_W + VALUE_WIDTH +: VALUE_WIDTH];

	// register file: index is the word address, low address bits ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			last_q  <= '1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FIRST) begin
				first_q <= pwdata[IDX_W-1:0];
			end else begin
				last_q <= pwdata[IDX_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_LAST) ? APB_DATA_W'(last_q) : APB_DATA_W'(first_q);

	tse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.opcode   (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tse_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.search_key   (search_key),
		.first_index  (first_q),
		.last_index   (last_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_found    (m_tuser),
		.out_position (out_position)
	);

	assign m_tdata = M_TDATA_W'(out_position);

endmodule

// ===== src/tse_checker.sv =====
// Port-level checks for the ternary search engine, bound to the top level.
// Depends on ternary_search_engine_defines.svh and tse_pkg.
`include "ternary_search_engine_defines.svh"

module tse_checker
	import tse_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [OPCODE_W-1:0]  s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser
);

	localparam logic [M_TDATA_W-1:0] POS_MAX = M_TDATA_W'(TABLE_DEPTH - 1);

	`TSE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
	`TSE_ASSERT_NEXT(a_search_busy, s_tvalid && s_tready && (s_tuser == OP_SEARCH), !s_tready, "input ready right after a search beat")
	`TSE_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "not-found result with nonzero position")
	`TSE_ASSERT_NOW(a_hit_range, m_tvalid && m_tuser, m_tdata <= POS_MAX, "found position outside the table")

endmodule

bind ternary_search_engine tse_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_tse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== dv/tb_top.sv =====
// Self-checking bench for the ternary search engine: stream beats in, APB setup.
// Holds the scoreboard class and the drivers; depends on tse_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
	import tse_pkg::*;

	localparam int TABLE_DEPTH   = 1024;
	localparam int VALUE_W       = 32;
	localparam int S_TDATA_W     = ((IDX_W + 2 * VALUE_W + 7) / 8) * 8;
	localparam int ITEM_TARGET   = 1400;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 1000000;

	localparam logic [APB_ADDR_W-1:0] ADDR_FIRST = APB_ADDR_W'(4 * int'(REG_FIRST));
	localparam logic [APB_ADDR_W-1:0] ADDR_LAST  = APB_ADDR_W'(4 * int'(REG_LAST));

	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

	// Shadow of the table and the range registers; predicts one lookup per search beat
	// and matches the result beats against them in order.
	class lookup_scoreboard;
		typedef struct {
			logic                 found;
			logic [IDX_W-1:0]     position;
		} lookup_t;

		logic signed [VALUE_W-1:0] value_mem [TABLE_DEPTH];
		bit                        stamped [TABLE_DEPTH];
		logic [IDX_W-1:0]          first_index;
		logic [IDX_W-1:0]          last_index;
		lookup_t                   pending_lookups [$];
		int                        failures;

		function new();
			first_index = '0;
			last_index  = IDX_W'(TABLE_DEPTH - 1);
			failures    = 0;
			foreach (value_mem[i]) value_mem[i] = '0;
			clear_stamps();
		endfunction

		function void clear_stamps();
			foreach (stamped[i]) stamped[i] = 1'b0;
		endfunction

		// Run the ternary search over the shadow table. Stop at the first probe
		// of an entry not stamped in this phase and report it through gap.
		function void walk(input logic signed [VALUE_W-1:0] key, output logic hit,
			output logic [IDX_W-1:0] pos, output int gap);
			int lo, hi, third, m1, m2;
			lo  = int'(first_index);
			hi  = (int'(last_index) > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : int'(last_index);
			hit = 1'b0;
			pos = '0;
			gap = -1;
			while (hi >= lo) begin
				third = (hi - lo) / 3;
				m1    = lo + third;
				m2    = hi - third;
				if (!stamped[m1]) begin
					gap = m1;
					return;
				end
				if (!stamped[m2]) begin
					gap = m2;
					return;
				end
				if (value_mem[m1] == key) begin
					hit = 1'b1;
					pos = m1[IDX_W-1:0];
					return;
				end
				if (value_mem[m2] == key) begin
					hit = 1'b1;
					pos = m2[IDX_W-1:0];
					return;
				end
				if (key < value_mem[m1]) begin
					hi = m1 - 1;
				end else if (key > value_mem[m2]) begin
					lo = m2 + 1;
				end else begin
					lo = m1 + 1;
					hi = m2 - 1;
				end
			end
		endfunction

		function void note_beat(input logic [OPCODE_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic signed [VALUE_W-1:0] val, input logic signed [VALUE_W-1:0] key);
			lookup_t want;
			int      gap;
			if (op == OP_WRITE) begin
				value_mem[idx] = val;
				stamped[idx]   = 1'b1;
			end else begin
				walk(key, want.found, want.position, gap);
				if (gap >= 0) begin
					failures++;
					$error("search beat would probe unwritten entry %0d", gap);
				end
				pending_lookups.push_back(want);
			end
		endfunction

		function void check_result(input logic found, input logic [IDX_W-1:0] position);
			lookup_t want;
			if (pending_lookups.size() == 0) begin
				failures++;
				$error("result beat with no lookup pending: found %0d position %0d",
					found, position);
				return;
			end
			want = pending_lookups.pop_front();
			if (found !== want.found) begin
				failures++;
				$error("found: expected %0d, actual %0d", want.found, found);
			end
			if (position !== want.position) begin
				failures++;
				$error("position: expected %0d, actual %0d", want.position, position);
			end
		endfunction

		function void check_reg(input string label, input logic [APB_DATA_W-1:0] want,
			input logic [APB_DATA_W-1:0] got);
			if (got !== want) begin
				failures++;
				$error("%s: expected %0d, actual %0d", label, want, got);
			end
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;   // entry_index, entry_value, search_key, zero pad
	logic [OPCODE_W-1:0]   s_tuser  = OP_WRITE;   // opcode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;   // position, zero pad
	logic                  m_tuser;   // found
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	lookup_scoreboard sb;
	bit          calm        = 1'b0;   // suppress idling on both sides
	int          beats_sent  = 0;
	int          stall_left  = 0;
	int unsigned cycle_count = 0;

	// Ascending fill used for on-demand writes: ramp_base at ramp_origin,
	// rising by ramp_step per index.
	longint ramp_base   = 0;
	longint ramp_step   = 1;
	int     ramp_origin = 0;

	ternary_search_engine #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_WIDTH(VALUE_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Abort on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Idle length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Receiver back-pressure: drop tready for random stretches.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(99) < 25)
				stall_left = pick_gap();
		end
	end

	// Check every accepted result beat against the oldest pending lookup.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[IDX_W-1:0]);
	end

	function automatic logic signed [VALUE_W-1:0] ramp(input int i);
		return VALUE_W'(ramp_base + longint'(i - ramp_origin) * ramp_step);
	endfunction

	// Idle the input by dropping tvalid; with n = 0 keep it up for back-to-back beats.
	task automatic pause_input(input int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Present one beat, hold it until accepted, then log it with the scoreboard.
	task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [IDX_W-1:0] idx,
		input logic signed [VALUE_W-1:0] val, input logic signed [VALUE_W-1:0] key);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_TDATA_W'({key, val, idx});
		do @(posedge clk); while (!s_tready);
		sb.note_beat(op, idx, val, key);
		beats_sent++;
		pause_input(pick_gap());
	endtask

	task automatic write_entry(input int idx, input logic signed [VALUE_W-1:0] val);
		send_beat(OP_WRITE, idx[IDX_W-1:0], val, $urandom);
	endtask

	// Fill every probe the search would touch from the ramp, then issue it.
	task automatic lookup_key(input logic signed [VALUE_W-1:0] key);
		logic             hit;
		logic [IDX_W-1:0] pos;
		int               gap;
		sb.walk(key, hit, pos, gap);
		while (gap >= 0) begin
			write_entry(gap, ramp(gap));
			sb.walk(key, hit, pos, gap);
		end
		send_beat(OP_SEARCH, IDX_W'($urandom), $urandom, key);
	endtask

	// Drop valid so the last beat is not taken again, then wait for every result.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending_lookups.size() != 0) @(posedge clk);
	endtask

	// One APB transfer: setup, access, then idle.
	task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write a range register, junk in the unused upper bits half the time, and read it back.
	task automatic set_register(input logic [APB_ADDR_W-1:0] addr, input int value,
		input string label);
		logic [APB_DATA_W-1:0] wdata;
		logic [APB_DATA_W-1:0] rd;
		wdata = APB_DATA_W'(value[IDX_W-1:0]);
		if ($urandom_range(1))
			wdata = wdata | ($urandom & ~APB_DATA_W'((1 << IDX_W) - 1));
		apb_access(1'b1, addr, wdata, rd);
		apb_access(1'b0, addr, '0, rd);
		sb.check_reg(label, APB_DATA_W'(value[IDX_W-1:0]), rd);
	endtask

	// Reprogram the search range once the engine has gone quiet.
	task automatic configure(input int lo_idx, input int hi_idx);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		set_register(ADDR_FIRST, lo_idx, "first_index");
		sb.first_index = lo_idx[IDX_W-1:0];
		set_register(ADDR_LAST, hi_idx, "last_index");
		sb.last_index = hi_idx[IDX_W-1:0];
	endtask

	// One random phase: pick a range and an ascending fill, then mostly searches
	// with a sprinkling of refreshes and out-of-order writes.
	task automatic random_phase(input bit hold_once);
		int                        pick, lo_idx, hi_idx, span, count, j, k;
		longint                    room;
		bit                        filled;
		logic signed [VALUE_W-1:0] key;
		pick = $urandom_range(99);
		if (pick < 45) begin
			span   = $urandom_range(0, 40);
			lo_idx = $urandom_range(0, TABLE_DEPTH - 1 - span);
			hi_idx = lo_idx + span;
		end else if (pick < 60) begin
			lo_idx = 0;
			hi_idx = TABLE_DEPTH - 1;
		end else if (pick < 70) begin
			lo_idx = 0;
			hi_idx = $urandom_range(0, TABLE_DEPTH - 1);
		end else if (pick < 80) begin
			lo_idx = $urandom_range(0, TABLE_DEPTH - 1);
			hi_idx = TABLE_DEPTH - 1;
		end else if (pick < 85) begin
			// empty range: first above last
			hi_idx = $urandom_range(0, TABLE_DEPTH - 2);
			lo_idx = $urandom_range(hi_idx + 1, TABLE_DEPTH - 1);
		end else if (pick < 90) begin
			lo_idx = pick[0] ? 0 : TABLE_DEPTH - 1;
			hi_idx = lo_idx;
		end else begin
			lo_idx = $urandom_range(0, TABLE_DEPTH - 1);
			hi_idx = $urandom_range(0, TABLE_DEPTH - 1);
		end
		configure(lo_idx, hi_idx);
		sb.clear_stamps();
		calm   = ($urandom_range(99) < 20);
		filled = (hi_idx >= lo_idx);

		// Choose a step that keeps the whole range inside the signed word.
		span = filled ? hi_idx - lo_idx : 0;
		pick = $urandom_range(99);
		if (pick < 10)
			ramp_step = 0;
		else if (pick < 40)
			ramp_step = $urandom_range(1, 3);
		else if (pick < 80)
			ramp_step = $urandom_range(1, 1000);
		else
			ramp_step = 64'd4294967295 / ((span > 0) ? span : 1);
		if (longint'(span) * ramp_step > 64'd4294967295)
			ramp_step = 64'd4294967295 / span;
		room = 64'd4294967295 - longint'(span) * ramp_step;
		pick = $urandom_range(99);
		ramp_origin = lo_idx;
		if (pick < 10)
			ramp_base = longint'(VALUE_MIN);
		else if (pick < 20)
			ramp_base = longint'(VALUE_MIN) + room;
		else
			ramp_base = longint'(VALUE_MIN) + longint'({32'b0, $urandom}) % (room + 1);

		count = $urandom_range(20, 90);
		for (j = 0; j < count && beats_sent < ITEM_TARGET; j++) begin
			// Hold off once, and now and then at random, until every pending lookup has come back.
			if ((hold_once && j == 10) || $urandom_range(99) < 2)
				wait_drained();
			pick = $urandom_range(99);
			if (pick < 8) begin
				// out-of-order write anywhere in the table
				write_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
			end else if (pick < 15 && filled) begin
				k = $urandom_range(lo_idx, hi_idx);
				write_entry(k, ramp(k));
			end else begin
				k = $urandom_range(99);
				if (filled && k < 50)
					key = ramp($urandom_range(lo_idx, hi_idx));
				else if (filled && k < 70)
					key = ramp($urandom_range(lo_idx, hi_idx)) + (k[0] ? 32'sd1 : -32'sd1);
				else if (k < 80)
					key = k[0] ? VALUE_MIN : VALUE_MAX;
				else
					key = $urandom;
				lookup_key(key);
			end
		end
	endtask

	initial begin
		logic [APB_DATA_W-1:0] rd;
		int                    i;
		bit                    first_phase;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Range registers must come out of reset at 0 and 1023.
		apb_access(1'b0, ADDR_FIRST, '0, rd);
		sb.check_reg("first_index", APB_DATA_W'(sb.first_index), rd);
		apb_access(1'b0, ADDR_LAST, '0, rd);
		sb.check_reg("last_index", APB_DATA_W'(sb.last_index), rd);

		// Directed: eight-entry table spanning the full signed range.
		configure(0, 7);
		ramp_base   = -1000;
		ramp_step   = 100;
		ramp_origin = 0;
		write_entry(0, VALUE_MIN);
		for (i = 1; i < 7; i++)
			write_entry(i, ramp(i));
		write_entry(7, VALUE_MAX);
		lookup_key(VALUE_MIN);
		lookup_key(VALUE_MAX);
		lookup_key(ramp(3));
		lookup_key(ramp(5) + 1);
		lookup_key(ramp(1) - 7);

		// Empty range: must miss without probing.
		configure(5, 2);
		lookup_key(ramp(5));

		// Single-entry range: hit and miss.
		configure(3, 3);
		lookup_key(ramp(3));
		lookup_key(ramp(3) + 1);

		// Break the ordering and search across the damage.
		configure(0, 7);
		write_entry(2, VALUE_MAX);
		lookup_key(VALUE_MAX);
		lookup_key(ramp(4));

		first_phase = 1'b1;
		while (beats_sent < ITEM_TARGET) begin
			random_phase(first_phase);
			first_phase = 1'b0;
		end

		// Drain: drop valid, collect the tail, allow for stray beats.
		calm = 1'b1;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
